// ----- rtl/hsid_pkg.sv -----
// shared types, codes and defaults for the hash set insert unit
package hsid_pkg;

    // field widths fixed by the interface
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = 10;

    // default geometry
    localparam int NUM_BUCKETS_DEF = 1021;
    localparam int WAYS_DEF        = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FILL,
        S_CMP
    } t_state;

    // remainder unit phases: two reciprocal halves, quotient back-multiply, subtract
    typedef enum logic [1:0] {
        M_LO,
        M_HI,
        M_QN,
        M_SUB
    } t_mod_phase;

    // handshake between the sequencer and the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_status;

endpackage

// ----- rtl/hsid_mod.sv -----
// remainder unit: key modulo bucket count by reciprocal multiply on one shared multiplier
module hsid_mod #(
    parameter int NUM_BUCKETS = hsid_pkg::NUM_BUCKETS_DEF,
    parameter int BKT_W       = $clog2(NUM_BUCKETS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hsid_pkg::KEY_W-1:0] i_key,
    output hsid_pkg::t_mod_status    o_status,
    output logic [BKT_W-1:0]         o_rem
);
    import hsid_pkg::*;

    localparam int MUL_W  = 17;
    localparam int PROD_W = KEY_W + MUL_W;
    localparam int ACC_W  = PROD_W + MUL_W;
    localparam int SHIFT  = KEY_W + $clog2(NUM_BUCKETS);
    // ceil(2^SHIFT / NUM_BUCKETS) gives the exact quotient for every 32-bit key
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [MUL_W-1:0] RECIP_LO = MUL_W'(RECIP);
    localparam logic [MUL_W-1:0] RECIP_HI = MUL_W'(RECIP >> MUL_W);
    localparam logic [MUL_W-1:0] DIVISOR  = MUL_W'(NUM_BUCKETS);

    t_mod_phase        r_phase, n_phase;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [BKT_W-1:0]  r_rem, n_rem;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [KEY_W-1:0]  w_mul_a;
    logic [MUL_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [KEY_W-1:0]  w_quot;
    logic [KEY_W-1:0]  w_diff;

    // shared multiplier, quotient and remainder
    assign w_prod = w_mul_a * w_mul_b;
    assign w_quot = KEY_W'(r_acc >> SHIFT);
    assign w_diff = r_key - r_acc[KEY_W-1:0];

    // phase sequence
    always_comb begin
        n_phase = r_phase;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_phase = M_LO;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            unique case (r_phase)
                M_LO:  n_phase = M_HI;
                M_HI:  n_phase = M_QN;
                M_QN:  n_phase = M_SUB;
                M_SUB: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: n_phase = M_LO;
            endcase
        end
    end

    // multiplier operands per phase
    always_comb begin
        w_mul_a = r_key;
        w_mul_b = RECIP_LO;
        unique case (r_phase)
            M_HI: w_mul_b = RECIP_HI;
            M_QN: begin
                w_mul_a = w_quot;
                w_mul_b = DIVISOR;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_key = r_key;
        n_acc = r_acc;
        n_rem = r_rem;
        if (i_start) begin
            n_key = i_key;
        end else if (r_busy) begin
            unique case (r_phase)
                M_LO:  n_acc = {{MUL_W{1'b0}}, w_prod};
                M_HI:  n_acc = r_acc + {w_prod, {MUL_W{1'b0}}};
                M_QN:  n_acc = {{MUL_W{1'b0}}, w_prod};
                M_SUB: n_rem = w_diff[BKT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= M_LO;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

// ----- rtl/hash_set_insert_dedup_unit.sv -----
// hash set insert with duplicate rejection over fixed-depth buckets
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+-----------------------------------
//  insert   | i_key                      | beat taken when start & !busy
//  result   | o_status, o_bucket         | one-cycle beat marked by o_valid
//
// an insert passes, after its accepting edge, through the multiply-based remainder
// unit (low and high reciprocal products, quotient back-multiply, subtract), the
// bucket hand-over, the fill read, then one key slot compare per cycle for 1 to WAYS
// key slots, then the result register. busy is low in the result cycle, so a new
// insert can be accepted in that cycle.
// after reset a clearing pass zeroes the fill counts, one bucket a cycle, with busy
// high. the result side cannot stall.
module hash_set_insert_dedup_unit #(
    parameter int NUM_BUCKETS = hsid_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = hsid_pkg::WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hsid_pkg::KEY_W-1:0]    i_key,
    output logic                          o_valid,
    output logic [hsid_pkg::STATUS_W-1:0] o_status,
    output logic [hsid_pkg::BUCKET_W-1:0] o_bucket
);
    import hsid_pkg::*;

    localparam int BKT_W     = $clog2(NUM_BUCKETS);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W    = $clog2(WAYS + 1);
    localparam int KEY_DEPTH = NUM_BUCKETS * (2 ** WAY_W);
    localparam int KADDR_W   = BKT_W + WAY_W;

    localparam logic [FILL_W-1:0] WAYS_F   = FILL_W'(WAYS);
    localparam logic [WAY_W-1:0]  LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

    // storage
    logic [KEY_W-1:0]  key_mem  [KEY_DEPTH];
    logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];

    // registers
    t_state            r_state, n_state;
    logic [KEY_W-1:0]  r_key;
    logic [BKT_W-1:0]  r_bucket;
    logic [WAY_W-1:0]  r_way, n_way;
    logic [BKT_W-1:0]  r_clr_idx;
    logic [KEY_W-1:0]  r_kq;
    logic [FILL_W-1:0] r_fill_q;
    logic              r_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [BKT_W-1:0]  r_out_bucket;

    // combinational controls
    t_mod_status       w_mod;
    logic [BKT_W-1:0]  w_rem;
    logic              w_accept;
    logic              w_mod_start;
    logic              w_fill_we;
    logic [BKT_W-1:0]  w_fill_addr;
    logic [FILL_W-1:0] w_fill_wdata;
    logic              w_key_we;
    logic [KADDR_W-1:0] w_key_waddr;
    logic [KADDR_W-1:0] w_key_raddr;
    logic [FILL_W-1:0] w_fill;
    logic              w_in_range;
    logic              w_hit;
    logic              w_cmp_done;
    logic              w_emit;
    logic [BKT_W+BUCKET_W-1:0] w_bucket_ext;

    assign w_accept = start && !busy;

    // remainder unit
    hsid_mod #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BKT_W       (BKT_W)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mod_start),
        .i_key    (i_key),
        .o_status (w_mod),
        .o_rem    (w_rem)
    );

    // slot compare against the way read last cycle
    always_comb begin
        w_fill     = (r_fill_q > WAYS_F) ? WAYS_F : r_fill_q;
        w_in_range = ({{FILL_W{1'b0}}, r_way} < {{WAY_W{1'b0}}, w_fill});
        w_hit      = w_in_range && (r_kq == r_key);
        w_cmp_done = !w_in_range || w_hit || (r_way == LAST_WAY);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == LAST_BKT) n_state = S_IDLE;
            S_IDLE:  if (start)                 n_state = S_DIV;
            S_DIV:   if (w_mod.done)            n_state = S_FILL;
            S_FILL:                             n_state = S_CMP;
            S_CMP:   if (w_cmp_done)            n_state = S_IDLE;
            default:                            n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_mod_start  = 1'b0;
        w_fill_we    = 1'b0;
        w_fill_addr  = r_bucket;
        w_fill_wdata = '0;
        w_key_we     = 1'b0;
        w_key_waddr  = {r_bucket, w_fill[WAY_W-1:0]};
        w_key_raddr  = {r_bucket, r_way + 1'b1};
        w_emit       = 1'b0;
        n_way        = r_way;
        n_status     = r_status;
        unique case (r_state)
            S_CLEAR: begin
                w_fill_we   = 1'b1;
                w_fill_addr = r_clr_idx;
            end
            S_IDLE: begin
                w_mod_start = w_accept;
            end
            S_DIV: begin
            end
            S_FILL: begin
                w_key_raddr = {r_bucket, {WAY_W{1'b0}}};
                n_way       = '0;
            end
            S_CMP: begin
                n_way = r_way + 1'b1;
                if (w_cmp_done) begin
                    w_emit = 1'b1;
                    if (w_hit) begin
                        n_status = ST_PRESENT;
                    end else if (w_fill == WAYS_F) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status     = ST_INSERTED;
                        w_key_we     = 1'b1;
                        w_fill_we    = 1'b1;
                        w_fill_wdata = w_fill + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= r_clr_idx + 1'b1;
            r_valid   <= w_emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_key;
        end
        if (r_state == S_DIV && w_mod.done) begin
            r_bucket <= w_rem;
        end
        if (w_emit) begin
            r_out_bucket <= r_bucket;
        end
        r_way    <= n_way;
        r_status <= n_status;
    end

    // key store, one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            key_mem[w_key_waddr] <= r_key;
        end
        r_kq <= key_mem[w_key_raddr];
    end

    // bucket fill counts
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            fill_mem[w_fill_addr] <= w_fill_wdata;
        end
        r_fill_q <= fill_mem[r_bucket];
    end

    // ports
    assign w_bucket_ext = {{BUCKET_W{1'b0}}, r_out_bucket};
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_bucket     = w_bucket_ext[BUCKET_W-1:0];

    // checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_INSERTED || o_status == ST_PRESENT ||
                     o_status == ST_FULL))
        else $error("result beat with an unused status code");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("insert beat taken but unit not busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    a_ready_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mod.busy)
        else $error("remainder unit running while idle");

endmodule

// ----- test/tb_hash_set_insert_dedup_unit.sv -----
// testbench for the hash set insert unit: directed and random key streams checked against a predictor
`timescale 1ns / 1ps

module tb_hash_set_insert_dedup_unit;

    import hsid_pkg::*;

    localparam int NUM_BUCKETS = NUM_BUCKETS_DEF;
    localparam int WAYS        = WAYS_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    // largest multiplier that keeps bucket + NUM_BUCKETS * k within 32 bits
    localparam longint unsigned K_MAX = (64'hFFFF_FFFF - NUM_BUCKETS) / NUM_BUCKETS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
    } t_insert_result;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic [KEY_W-1:0]    i_key   = '0;
    logic                busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [BUCKET_W-1:0] o_bucket;

    // predictor state: key slots per bucket and fill counts
    logic [KEY_W-1:0] set_slots [NUM_BUCKETS*WAYS];
    int unsigned      set_fill  [NUM_BUCKETS];

    t_insert_result   pending_results[$];
    logic [KEY_W-1:0] stored_keys[$];
    int               error_count = 0;
    int               cycle_count = 0;
    bit               gaps_on     = 1'b1;

    hash_set_insert_dedup_unit #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .WAYS       (WAYS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_key   (i_key),
        .o_valid (o_valid),
        .o_status(o_status),
        .o_bucket(o_bucket)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // look up the key in its bucket, store it if absent and there is room
    function automatic t_insert_result predict_insert(input logic [KEY_W-1:0] key);
        int unsigned    bkt;
        int unsigned    fill;
        bit             hit;
        t_insert_result res;
        bkt  = key % NUM_BUCKETS;
        fill = set_fill[bkt];
        hit  = 1'b0;
        if (fill > WAYS) fill = WAYS;
        for (int unsigned w = 0; w < fill; w++) begin
            if (set_slots[bkt*WAYS + w] == key) hit = 1'b1;
        end
        if (hit) begin
            res.status = ST_PRESENT;
        end else if (fill >= WAYS) begin
            res.status = ST_FULL;
        end else begin
            set_slots[bkt*WAYS + fill] = key;
            set_fill[bkt]              = fill + 1;
            res.status                 = ST_INSERTED;
            stored_keys.push_back(key);
        end
        res.bucket = bkt[BUCKET_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] key_for_bucket(input int unsigned bkt,
                                                        input longint unsigned k);
        longint unsigned v;
        v = bkt + longint'(NUM_BUCKETS) * k;
        return v[KEY_W-1:0];
    endfunction

    // one insert beat, then an optional hold-off from the sender
    task automatic send_key(input logic [KEY_W-1:0] key);
        t_insert_result predicted;
        start <= 1'b1;
        i_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_insert(key);
        pending_results.push_back(predicted);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            // gap either right after the beat or after the block drops busy
            if ($urandom_range(0, 1)) begin
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_insert_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d bucket %0d",
                       o_status, o_bucket);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_bucket !== want.bucket) begin
                    $error("bucket: expected %0d, got %0d", want.bucket, o_bucket);
                    error_count++;
                end
            end
        end
    end

    // extremes, duplicates and overflow of a bucket
    task automatic test_directed();
        send_key(32'd0);
        send_key(32'd0);
        send_key(32'hFFFF_FFFF);
        send_key(32'hFFFF_FFFF);
        send_key(NUM_BUCKETS - 1);
        // fill bucket zero, then overflow it
        for (int k = 1; k < WAYS; k++) send_key(key_for_bucket(0, k));
        send_key(key_for_bucket(0, WAYS));
        // duplicates in a full bucket
        send_key(key_for_bucket(0, 2));
        send_key(32'd0);
        send_key(32'd1);
        send_key(32'h8000_0000);
        send_key(32'h7FFF_FFFF);
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);
        // top bucket filled and overflowed
        for (int k = 1; k <= WAYS; k++) send_key(key_for_bucket(NUM_BUCKETS - 1, k));
        send_key(key_for_bucket(NUM_BUCKETS - 1, K_MAX));
    endtask

    // two sets streamed back to back, the second partly overlapping the first
    task automatic test_union(input int set_size);
        logic [KEY_W-1:0] set_a[$];
        for (int i = 0; i < set_size; i++) begin
            set_a.push_back(key_for_bucket($urandom_range(0, NUM_BUCKETS - 1),
                                           $urandom_range(0, 15)));
            send_key(set_a[i]);
        end
        for (int i = 0; i < set_size; i++) begin
            if ($urandom_range(0, 1)) send_key(set_a[$urandom_range(0, set_size - 1)]);
            else send_key(key_for_bucket($urandom_range(0, NUM_BUCKETS - 1),
                                         $urandom_range(0, 15)));
        end
    endtask

    // keys packed into a few buckets so they fill, overflow and repeat
    task automatic test_crowded_buckets(input int n_items);
        int unsigned hot[8];
        int unsigned pick;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                foreach (hot[j]) hot[j] = $urandom_range(0, NUM_BUCKETS - 1);
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_key(key_for_bucket(hot[$urandom_range(0, 7)], $urandom_range(0, 7)));
            else if (pick < 8 && stored_keys.size() != 0)
                send_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else if (pick < 9)
                send_key(key_for_bucket(hot[$urandom_range(0, 7)],
                                        $urandom_range(0, 32'(K_MAX))));
            else
                send_key($urandom);
        end
    endtask

    // keys over the whole range, near both ends, and repeats of stored ones
    task automatic test_scattered_keys(input int n_items);
        int unsigned pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_key($urandom);
            else if (pick < 7 && stored_keys.size() != 0)
                send_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else if (pick < 8)
                send_key($urandom_range(0, 3000));
            else
                send_key(32'hFFFF_FFFF - $urandom_range(0, 3000));
        end
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < NUM_BUCKETS; i++) set_fill[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_union(30);
        test_crowded_buckets(600);
        test_scattered_keys(420);
        // steady stream with no hold-off
        gaps_on = 1'b0;
        test_crowded_buckets(250);
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (WAYS + 40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
